FILE: src/adv_manuf_counter_extractor_assert.svh
// Assertion macros used by the counter extractor checker.
`ifndef ADV_MANUF_COUNTER_EXTRACTOR_ASSERT_SVH
`define ADV_MANUF_COUNTER_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AMCE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("counter extractor assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AMCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("counter extractor assertion failed");

`endif

FILE: src/amce_pkg.sv
// Types and constants shared by the counter extractor modules.
`timescale 1ns / 1ps

package amce_pkg;

   // Request kinds carried on tuser.
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_SYNC = 1'b1;

   // Record constants.
   localparam logic [7:0] MANUF_TYPE  = 8'hFF;
   localparam logic [7:0] MIN_REC_LEN = 8'd7;
   localparam logic [7:0] CNT_FIRST   = 8'd2;
   localparam logic [7:0] CNT_END     = 8'd6;
   localparam logic [7:0] CNT_LAST    = 8'd5;
   localparam logic [7:0] POS_MAX     = 8'hFF;

   // One accepted request.
   typedef struct packed {
      logic       opcode;
      logic       sync_ok;
      logic [7:0] data_byte;
      logic [7:0] report_len;
      logic       last_of_report;
   } req_item_type;

   // One result with its valid flag.
   typedef struct packed {
      logic        valid;
      logic        first_after_sync;
      logic [31:0] delta;
      logic [31:0] counter;
   } rsp_item_type;

endpackage

FILE: src/adv_manuf_counter_extractor.sv
// Top level of the manufacturer-record counter extractor.
`timescale 1ns / 1ps
//
// Takes periodic advertising reports one byte per request on the req_ channel
// and walks their length-type records. The first manufacturer record of
// sufficient length yields a 32-bit little-endian counter, returned on the
// rsp_ channel with its wrapping difference from the previous counter and a
// flag marking the first counter since reset or a successful sync event.
// A sync request (tuser high) re-arms that flag when sync_ok is set.
// Each request is taken into an input register, evaluated there once the result
// register can take its outcome and, when it completes a counter, lands in the
// result register, which drives rsp_tvalid. One request is accepted per cycle
// while the result register is not stalled, with one state update per request.
// Reset (synchronous, active high) restarts the walk, clears the previous
// counter and arms the first flag; req_tready is low during reset.
// When the receiver stalls, the result holds in the output register while the
// input register still takes one further request, then req_tready falls.
//

module adv_manuf_counter_extractor
   import amce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sync_ok [0], data_byte [8:1], report_len [16:9], zero pad
   input  logic        req_tuser,   // opcode
   input  logic        req_tlast,   // last_of_report
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // counter [31:0], delta [63:32]
   output logic        rsp_tuser    // first_after_sync
);

   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff;
   rsp_item_type res;
   logic         free;
   logic         step;
   logic         req_accept;

   // Input stage advances whenever the result register can take its outcome.
   assign step       = in_valid_ff && free;
   assign req_tready = !reset && (!in_valid_ff || free);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.opcode         <= req_tuser;
         item_ff.sync_ok        <= req_tdata[0];
         item_ff.data_byte      <= req_tdata[8:1];
         item_ff.report_len     <= req_tdata[16:9];
         item_ff.last_of_report <= req_tlast;
      end
   end

   amce_walker u_walker (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item_ff),
      .res   (res)
   );

   amce_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .res        (res),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/amce_walker.sv
// Record walker: parse state, counter capture and result formation.
`timescale 1ns / 1ps

module amce_walker
   import amce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type res
);

   localparam logic [1:0] PH_LEN  = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  rec_len_ff, rec_len_in;
   logic [7:0]  offset_ff, offset_in;
   logic        match_ff, match_in;
   logic [31:0] capture_ff, capture_in;
   logic [31:0] prev_ff, prev_in;
   logic        first_ff, first_in;

   logic [31:0] capture_shift;
   logic [8:0]  pos_plus1;
   logic [9:0]  rec_end;
   logic [7:0]  offset_next;

   assign capture_shift = {item.data_byte, capture_ff[31:8]};
   assign pos_plus1     = {1'b0, pos_ff} + 9'd1;
   assign rec_end       = {2'b00, pos_ff} + 10'd1 + {2'b00, item.data_byte};
   assign offset_next   = offset_ff + 8'd1;

   // Next state and result for the request held in the input register.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      rec_len_in = rec_len_ff;
      offset_in  = offset_ff;
      match_in   = match_ff;
      capture_in = capture_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      res.valid            = 1'b0;
      res.counter          = capture_shift;
      res.delta            = first_ff ? 32'd0 : capture_shift - prev_ff;
      res.first_after_sync = first_ff;
      if (step) begin
         if (item.opcode == OP_SYNC) begin
            if (item.sync_ok) begin
               first_in = 1'b1;
            end
         end else begin
            if (phase_ff != PH_DONE && pos_ff < item.report_len) begin
               unique case (phase_ff)
                  PH_LEN: begin
                     if (pos_plus1 >= {1'b0, item.report_len} || item.data_byte == 8'd0 ||
                         rec_end > {2'b00, item.report_len}) begin
                        phase_in = PH_DONE;
                     end else begin
                        rec_len_in = item.data_byte;
                        phase_in   = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     match_in   = (item.data_byte == MANUF_TYPE) && (rec_len_ff >= MIN_REC_LEN);
                     offset_in  = 8'd0;
                     capture_in = 32'd0;
                     phase_in   = (rec_len_ff <= 8'd1) ? PH_LEN : PH_BODY;
                  end
                  PH_BODY: begin
                     // Counter bytes follow the two-byte company id.
                     if (match_ff && offset_ff >= CNT_FIRST && offset_ff < CNT_END) begin
                        capture_in = capture_shift;
                        if (offset_ff == CNT_LAST) begin
                           res.valid = 1'b1;
                           prev_in   = capture_shift;
                           first_in  = 1'b0;
                           phase_in  = PH_DONE;
                        end
                     end
                     if (phase_in == PH_BODY) begin
                        offset_in = offset_next;
                        if ({1'b0, offset_next} + 9'd1 >= {1'b0, rec_len_ff}) begin
                           phase_in = PH_LEN;
                        end
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 8'd1;
            end
            // The walk restarts after the final byte of a report.
            if (item.last_of_report) begin
               phase_in   = PH_LEN;
               pos_in     = 8'd0;
               rec_len_in = 8'd0;
               offset_in  = 8'd0;
               match_in   = 1'b0;
               capture_in = 32'd0;
            end
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         pos_ff     <= 8'd0;
         rec_len_ff <= 8'd0;
         offset_ff  <= 8'd0;
         match_ff   <= 1'b0;
         capture_ff <= 32'd0;
         prev_ff    <= 32'd0;
         first_ff   <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         rec_len_ff <= rec_len_in;
         offset_ff  <= offset_in;
         match_ff   <= match_in;
         capture_ff <= capture_in;
         prev_ff    <= prev_in;
         first_ff   <= first_in;
      end
   end

endmodule

FILE: src/amce_out_reg.sv
// Result register driving the response channel.
`timescale 1ns / 1ps

module amce_out_reg
   import amce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type res,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // counter [31:0], delta [63:32]
   output logic         rsp_tuser    // first_after_sync
);

   logic        valid_ff, valid_in;
   logic [31:0] counter_ff;
   logic [31:0] delta_ff;
   logic        first_ff;

   // The register can take a new result when empty or being drained.
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = res.valid;
      end else begin
         valid_in = valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is captured only when a result is produced.
   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         counter_ff <= res.counter;
         delta_ff   <= res.delta;
         first_ff   <= res.first_after_sync;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {delta_ff, counter_ff};
   assign rsp_tuser  = first_ff;

endmodule

FILE: src/amce_checker.sv
// Port-level checker for the counter extractor, bound to the top level.
`timescale 1ns / 1ps
`include "adv_manuf_counter_extractor_assert.svh"

module amce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic        rsp_stall;
   logic        rsp_first;
   logic [64:0] rsp_word;
   logic [31:0] rsp_delta;
   logic        data_accept;

   // Observed conditions on the two channels.
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_first   = rsp_tvalid && rsp_tuser;
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign rsp_delta   = rsp_tdata[63:32];
   assign data_accept = req_tvalid && req_tready && !req_tuser;

   // A stalled result holds its value.
   `AMCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // The first counter after sync carries a zero difference.
   `AMCE_ASSERT_IMPLY(a_first_zero_delta, clock, reset, rsp_first, rsp_delta == 32'd0)

   // With the result side empty the block always takes a request.
   `AMCE_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // A fresh result stems from an accepted data byte, via the input and result registers.
   `AMCE_ASSERT_IMPLY(a_result_source, clock, reset, $rose(rsp_tvalid), $past(data_accept, 2))

endmodule

bind adv_manuf_counter_extractor amce_checker u_amce_checker (.*);
